>>> hw/rtl/ptpe_pkg.sv
// Shared types and constants for the two-level page table engine.
package ptpe_pkg;

  // Table geometry
  localparam int DIR_ENTRIES   = 1024;
  localparam int TABLE_ENTRIES = 1024;
  localparam int TABLE_SLOTS   = 64;

  localparam int IDX_W  = 10;                                   // index width of either level
  localparam int LINK_W = $clog2(TABLE_SLOTS + 1);              // directory entry: 0 empty, k slot k-1
  localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int TAB_AW = SLOT_W + IDX_W;
  localparam int TAB_DEPTH = TABLE_SLOTS * TABLE_ENTRIES;

  typedef enum logic [1:0] {
    CMD_MAP    = 2'd0,
    CMD_UNMAP  = 2'd1,
    CMD_LOOKUP = 2'd2
  } ptpe_cmd_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } ptpe_status_t;

  typedef enum logic [2:0] {
    S_CLR_DIR,
    S_IDLE,
    S_DIR_RD,
    S_PAGE_CLR,
    S_MAP_WR,
    S_TAB_RD
  } ptpe_state_t;

  typedef struct packed {
    ptpe_cmd_t   command;
    logic [31:0] virt_addr;
    logic [31:0] phys_addr;
    logic [11:0] flags;
  } ptpe_in_t;

  typedef struct packed {
    ptpe_status_t status;
    logic [31:0]  frame_addr;
    logic         invalidate;
    logic [31:0]  invalidate_addr;
  } ptpe_out_t;

endpackage

>>> hw/rtl/ptpe_ram.sv
// Generic simple dual-port RAM with registered read.
module ptpe_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/two_level_page_table_engine.sv
// Two-level page table engine: directory and table memories with a command sequencer.
//
// Issue a command by raising start while busy is low; the item is taken at that edge
// and busy stays high until the result is shown. The result appears on out_data for
// exactly one cycle with out_valid high and cannot be held off, so capture it then.
// Unmap, a map into an existing table and a failed command need one directory memory
// read before the result strobe; a lookup goes through a directory read, then a table
// read. A map that has to allocate a table page first zeroes the new page one word per
// cycle through the table memory's write port, then writes the mapping. A new item can
// be started in the cycle the result is shown. After reset the block holds busy high
// while it clears the directory, one entry per cycle.
module two_level_page_table_engine
  import ptpe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  ptpe_in_t  in_data,
  output logic      out_valid,
  output ptpe_out_t out_data
);

  localparam logic [IDX_W-1:0] IDX_LAST = {IDX_W{1'b1}};

  ptpe_state_t        state_r, state_nxt;
  ptpe_in_t           item_r, item_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [LINK_W-1:0]  free_r, free_nxt;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  ptpe_out_t          out_r, out_nxt;

  // Memory ports
  logic               dir_we;
  logic [IDX_W-1:0]   dir_waddr;
  logic [LINK_W-1:0]  dir_wdata;
  logic [LINK_W-1:0]  dir_rd_data;
  logic               tab_we;
  logic [TAB_AW-1:0]  tab_waddr;
  logic [31:0]        tab_wdata;
  logic [TAB_AW-1:0]  tab_raddr;
  logic [31:0]        tab_rd_data;

  logic [IDX_W-1:0]   di;
  logic [IDX_W-1:0]   ti;
  logic [SLOT_W-1:0]  link_slot;
  logic [31:0]        map_entry;
  logic [LINK_W-1:0]  link_dec;

  assign di        = item_r.virt_addr[31:22];
  assign ti        = item_r.virt_addr[21:12];
  assign link_dec  = dir_rd_data - LINK_W'(1);
  assign link_slot = link_dec[SLOT_W-1:0];
  assign map_entry = {item_r.phys_addr[31:12], item_r.flags};

  ptpe_ram #(
    .WIDTH  (LINK_W),
    .DEPTH  (DIR_ENTRIES),
    .ADDR_W (IDX_W)
  ) u_dir_ram (
    .clk     (clk),
    .wr_en   (dir_we),
    .wr_addr (dir_waddr),
    .wr_data (dir_wdata),
    .rd_addr (in_data.virt_addr[31:22]),
    .rd_data (dir_rd_data)
  );

  ptpe_ram #(
    .WIDTH  (32),
    .DEPTH  (TAB_DEPTH),
    .ADDR_W (TAB_AW)
  ) u_tab_ram (
    .clk     (clk),
    .wr_en   (tab_we),
    .wr_addr (tab_waddr),
    .wr_data (tab_wdata),
    .rd_addr (tab_raddr),
    .rd_data (tab_rd_data)
  );

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR_DIR;
      free_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_r      <= free_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    slot_r <= slot_nxt;
    out_r  <= out_nxt;
  end

  // Sequencer: next state, memory controls and result
  always_comb begin
    ptpe_out_t res;
    logic      emit;

    state_nxt = state_r;
    item_nxt  = item_r;
    slot_nxt  = slot_r;
    free_nxt  = free_r;
    cnt_nxt   = cnt_r;
    dir_we    = 1'b0;
    dir_waddr = di;
    dir_wdata = '0;
    tab_we    = 1'b0;
    tab_waddr = {link_slot, ti};
    tab_wdata = '0;
    tab_raddr = {link_slot, ti};
    res       = '0;
    emit      = 1'b0;

    unique case (state_r)
      // Sweep the directory to empty after reset
      S_CLR_DIR: begin
        dir_we    = 1'b1;
        dir_waddr = cnt_r;
        cnt_nxt   = cnt_r + IDX_W'(1);
        if (cnt_r == IDX_LAST) begin
          state_nxt = S_IDLE;
        end
      end

      // Directory read is issued straight from the input port
      S_IDLE: begin
        if (start) begin
          item_nxt  = in_data;
          state_nxt = S_DIR_RD;
        end
      end

      // Directory entry is on dir_rd_data
      S_DIR_RD: begin
        unique case (item_r.command)
          CMD_MAP: begin
            if (dir_rd_data == '0) begin
              if (free_r < LINK_W'(TABLE_SLOTS)) begin
                // allocate next pool page and link it
                dir_we    = 1'b1;
                dir_wdata = free_r + LINK_W'(1);
                slot_nxt  = free_r[SLOT_W-1:0];
                free_nxt  = free_r + LINK_W'(1);
                cnt_nxt   = '0;
                state_nxt = S_PAGE_CLR;
              end else begin
                res.status = STAT_FULL;
                emit       = 1'b1;
                state_nxt  = S_IDLE;
              end
            end else begin
              tab_we                = 1'b1;
              tab_wdata             = map_entry;
              res.invalidate        = 1'b1;
              res.invalidate_addr   = item_r.virt_addr;
              emit                  = 1'b1;
              state_nxt             = S_IDLE;
            end
          end
          CMD_UNMAP: begin
            if (dir_rd_data == '0) begin
              res.status = STAT_MISS;
            end else begin
              tab_we              = 1'b1;
              res.invalidate      = 1'b1;
              res.invalidate_addr = item_r.virt_addr;
            end
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end
          CMD_LOOKUP: begin
            if (dir_rd_data == '0) begin
              res.status = STAT_MISS;
              emit       = 1'b1;
              state_nxt  = S_IDLE;
            end else begin
              state_nxt = S_TAB_RD;
            end
          end
          default: begin
            // unused command: no state change, all-zero result
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end

      // Zero the newly allocated page
      S_PAGE_CLR: begin
        tab_we    = 1'b1;
        tab_waddr = {slot_r, cnt_r};
        cnt_nxt   = cnt_r + IDX_W'(1);
        if (cnt_r == IDX_LAST) begin
          state_nxt = S_MAP_WR;
        end
      end

      // Store the mapping into the fresh page
      S_MAP_WR: begin
        tab_we              = 1'b1;
        tab_waddr           = {slot_r, ti};
        tab_wdata           = map_entry;
        res.invalidate      = 1'b1;
        res.invalidate_addr = item_r.virt_addr;
        emit                = 1'b1;
        state_nxt           = S_IDLE;
      end

      // Table entry is on tab_rd_data
      S_TAB_RD: begin
        if (tab_rd_data != '0) begin
          res.frame_addr = {tab_rd_data[31:12], 12'h000};
        end else begin
          res.status = STAT_MISS;
        end
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = emit;
    out_nxt       = emit ? res : out_r;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> hw/rtl/ptpe_checker.sv
// Port-level checks for the page table engine, bound to the top level.
module ptpe_checker
  import ptpe_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input ptpe_out_t out_data
);

  // An accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // A result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // Results are shown only once the block is free again
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // Invalidate goes with success and carries the address only then
  a_inval_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.invalidate ? (out_data.status == STAT_OK)
                                       : (out_data.invalidate_addr == '0)))
    else $error("invalidate inconsistent with status");

  // Failure results carry no frame and the frame is page aligned
  a_frame_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.frame_addr[11:0] == 12'h000) &&
                  ((out_data.status == STAT_OK) || (out_data.frame_addr == '0)))
    else $error("bad frame address in result");

endmodule

bind two_level_page_table_engine ptpe_checker u_ptpe_checker (.*);

>>> test/page_table_checker.sv
// Checker for the page table engine: mirrors the tables, predicts each result and compares.
module page_table_checker
  import ptpe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  ptpe_in_t  in_data,
  input  logic      out_valid,
  input  ptpe_out_t out_data,
  output int        fail_count,
  output int        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Mirror of the tables: directory links (0 empty, k = slot k-1) and page words
  int unsigned dir_link [DIR_ENTRIES];
  logic [31:0] page_word [TAB_DEPTH];
  int unsigned pages_taken;

  ptpe_out_t due_results [$];
  int        mismatches;

  // Apply one command to the mirror and return the result it should produce
  function automatic ptpe_out_t walk_table(ptpe_in_t item);
    ptpe_out_t   res;
    int unsigned di;
    int unsigned ti;
    int unsigned link;
    logic [31:0] entry;
    res    = '0;
    di     = item.virt_addr[31:22];
    ti     = item.virt_addr[21:12];
    link   = dir_link[di];
    entry  = '0;
    res.status = STAT_OK;
    case (item.command)
      CMD_MAP: begin
        // empty directory slot: take the next page from the pool and zero it
        if (link == 0 && pages_taken < TABLE_SLOTS) begin
          for (int w = 0; w < TABLE_ENTRIES; w++)
            page_word[pages_taken * TABLE_ENTRIES + w] = '0;
          pages_taken++;
          link = pages_taken;
          dir_link[di] = link;
        end
        if (link == 0) begin
          res.status = STAT_FULL;
        end else begin
          page_word[(link - 1) * TABLE_ENTRIES + ti] = {item.phys_addr[31:12], item.flags};
          res.invalidate      = 1'b1;
          res.invalidate_addr = item.virt_addr;
        end
      end
      CMD_UNMAP: begin
        if (link == 0) begin
          res.status = STAT_MISS;
        end else begin
          page_word[(link - 1) * TABLE_ENTRIES + ti] = '0;
          res.invalidate      = 1'b1;
          res.invalidate_addr = item.virt_addr;
        end
      end
      CMD_LOOKUP: begin
        if (link != 0)
          entry = page_word[(link - 1) * TABLE_ENTRIES + ti];
        // flag bits alone still count as a hit, with frame zero
        if (entry != '0)
          res.frame_addr = {entry[31:12], 12'h000};
        else
          res.status = STAT_MISS;
      end
      default: ;  // reserved code: no effect, all-zero result
    endcase
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Results are popped before a new item is pushed: a result never belongs
  // to an item taken at the same edge
  always @(posedge clk) begin
    ptpe_out_t want;
    if (!rst_n) begin
      foreach (dir_link[i]) dir_link[i] = 0;
      pages_taken = 0;
      due_results.delete();
    end else begin
      if (out_valid) begin
        if (due_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with no item outstanding: expected none, got %h",
                   $time, out_data);
        end else begin
          want = due_results.pop_front();
          check_field("status", 32'(want.status), 32'(out_data.status));
          check_field("frame_addr", want.frame_addr, out_data.frame_addr);
          check_field("invalidate", 32'(want.invalidate), 32'(out_data.invalidate));
          check_field("invalidate_addr", want.invalidate_addr, out_data.invalidate_addr);
        end
      end
      if (start && !busy)
        due_results.push_back(walk_table(in_data));
    end
    outstanding <= due_results.size();
    fail_count  <= mismatches;
  end

endmodule

>>> test/tb.sv
// Testbench top for the page table engine: clock, reset, command stimulus and verdict.
module tb
  import ptpe_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_RESERVED = 2'd3;
  localparam int RANDOM_ITEMS = 2000;
  localparam int QUIET_TAIL   = 300;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int SETTLE       = 1100;   // beyond the longest latency (page allocation)

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  ptpe_in_t  in_data = '0;
  logic      busy;
  logic      out_valid;
  ptpe_out_t out_data;
  int        fail_count;
  int        outstanding;

  logic [9:0]  hot_dir [8];
  logic [31:0] mapped_va [$];

  always #5 clk = ~clk;

  two_level_page_table_engine u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  page_table_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Present one command and hold it until the block takes it
  task automatic issue(input ptpe_cmd_t cmd, input logic [31:0] va,
                       input logic [31:0] pa, input logic [11:0] fl);
    start   <= 1'b1;
    in_data <= '{command: cmd, virt_addr: va, phys_addr: pa, flags: fl};
    do @(posedge clk); while (busy);
  endtask

  task automatic pause_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Hold off until every issued command has returned its result
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    #5ms;
    $display("** two_level_page_table_engine: FAILED **");
    $finish;
  end

  initial begin
    ptpe_cmd_t   cmd;
    logic [31:0] va;
    logic [31:0] pa;
    logic [11:0] fl;
    int          sel;
    int          waited;
    bit          gappy;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: misses with no table, extremes of the fields, zero entries,
    // flag-only entries, overwrite, unmap of an unmapped entry, reserved code
    issue(CMD_LOOKUP, 32'h0000_0000, 32'h0, 12'h000);
    issue(CMD_UNMAP,  32'h0000_0000, 32'h0, 12'h000);
    issue(CMD_MAP,    32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF);
    issue(CMD_LOOKUP, 32'h0000_0FFF, 32'h0, 12'h000);
    issue(CMD_LOOKUP, 32'h0000_1000, 32'h0, 12'h000);
    issue(CMD_MAP,    32'h0000_1FFF, 32'h0000_0000, 12'h000);
    issue(CMD_LOOKUP, 32'h0000_1000, 32'h0, 12'h000);
    issue(CMD_MAP,    32'h0000_2000, 32'h0000_0ABC, 12'h001);
    issue(CMD_LOOKUP, 32'h0000_2000, 32'h0, 12'h000);
    issue(CMD_UNMAP,  32'h0000_0000, 32'h0, 12'h000);
    issue(CMD_LOOKUP, 32'h0000_0000, 32'h0, 12'h000);
    issue(CMD_UNMAP,  32'h0000_3000, 32'h0, 12'h000);
    issue(CMD_MAP,    32'hFFFF_FFFF, 32'h1234_5FFF, 12'hAAA);
    issue(CMD_LOOKUP, 32'hFFFF_F000, 32'h0, 12'h000);
    issue(CMD_MAP,    32'hFFC0_0000, 32'h8000_0000, 12'h555);
    issue(CMD_LOOKUP, 32'hFFC0_0FFF, 32'h0, 12'h000);
    issue(ptpe_cmd_t'(CMD_RESERVED), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
    issue(ptpe_cmd_t'(CMD_RESERVED), 32'h0000_0000, 32'h0000_0000, 12'h000);
    issue(CMD_LOOKUP, 32'hFFBF_F000, 32'h0, 12'h000);
    issue(CMD_MAP,    32'hFFFF_F000, 32'h0000_0000, 12'hFFF);
    issue(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 12'h000);
    issue(CMD_UNMAP,  32'hFFBF_F000, 32'h0, 12'h000);
    drain();

    // A few hot directories keep most traffic inside existing tables;
    // scattered addresses slowly use up the page pool until maps fail
    hot_dir[0] = 10'h000;
    hot_dir[1] = 10'h3FF;
    for (int i = 2; i < 8; i++) hot_dir[i] = 10'($urandom);
    mapped_va.push_back(32'h0000_2000);
    mapped_va.push_back(32'hFFC0_0000);
    gappy = 1'b1;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45)      cmd = CMD_MAP;
      else if (sel < 63) cmd = CMD_UNMAP;
      else if (sel < 97) cmd = CMD_LOOKUP;
      else               cmd = ptpe_cmd_t'(CMD_RESERVED);

      sel = $urandom_range(0, 99);
      if (sel < 50 && mapped_va.size() != 0)
        va = {mapped_va[$urandom_range(0, mapped_va.size() - 1)][31:12], 12'($urandom)};
      else if (sel < 85)
        va = {hot_dir[$urandom_range(0, 7)], 10'($urandom), 12'($urandom)};
      else
        va = $urandom;

      pa = $urandom;
      fl = 12'($urandom_range(0, 4095));
      // an all-zero entry reads back as unmapped
      if ($urandom_range(0, 19) == 0) begin
        pa[31:12] = '0;
        fl        = '0;
      end

      if (cmd == CMD_MAP) begin
        mapped_va.push_back(va);
        if (mapped_va.size() > 64) void'(mapped_va.pop_front());
      end

      issue(cmd, va, pa, fl);

      if (n == RANDOM_ITEMS / 2)
        drain();
      else if (n < RANDOM_ITEMS - QUIET_TAIL && gappy && $urandom_range(0, 3) == 0)
        pause_cycles($urandom_range(1, 14));

      // alternate stretches with and without gaps
      if (n % 100 == 99) gappy = ($urandom_range(0, 2) != 0);
    end

    // Let every result come back, then watch for stray strobes
    start  <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (outstanding != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE) @(posedge clk);

    if (outstanding != 0)
      $display("%0t: %0d results never arrived", $time, outstanding);
    if (fail_count == 0 && outstanding == 0)
      $display("** two_level_page_table_engine: PASSED **");
    else
      $display("** two_level_page_table_engine: FAILED **");
    $finish;
  end

endmodule
